### rtl/ppg_pkg.sv
// shared types, constants and sine table builder for the plasma pixel pair generator
`default_nettype none

package ppg_pkg;

	localparam int TABLE_SIZE   = 4096;
	localparam int IDX_W        = $clog2(TABLE_SIZE);
	localparam int PALETTE_SIZE = 256;
	localparam int SUM_W        = $clog2(PALETTE_SIZE);
	localparam int ADDR_SUM_W   = 12;
	localparam int INNER_W      = 12;

	typedef enum logic [1:0] {
		TBL_ONE,
		TBL_TWO,
		TBL_THREE
	} table_sel_t;

	localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
	localparam logic [63:0] PI_Q56      = PI_Q62 >> 6;
	localparam logic [63:0] TWO_PI_Q56  = PI_Q56 * 64'd2;
	localparam logic [63:0] HALF_PI_Q56 = PI_Q62 >> 7;
	localparam logic [63:0] ONE_Q56     = 64'd1 << 56;

	localparam logic [63:0] DIV_ONE   = 64'd45;
	localparam logic [63:0] DIV_TWO   = 64'd75;
	localparam logic [63:0] DIV_THREE = 64'd32;
	localparam logic [63:0] AMP_ONE   = 64'd63;
	localparam logic [63:0] AMP_TWO   = 64'd42;
	localparam logic [63:0] AMP_THREE = 64'd88;

	localparam int SERIES_TERMS = 13;
	localparam logic [63:0] SERIES_DEN [SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
	};

	localparam logic [6:0] FOLD_POINT = 7'd127;
	localparam logic [4:0] LEVEL_MAX  = 5'd31;

	// truncated (a*b) >> 62
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// floor(sin(i/div)*amp + amp) in fixed point
	function automatic logic [7:0] sine_entry(input logic [63:0] i, input table_sel_t sel);
		logic [63:0] th;
		logic [63:0] amp;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] p;
		logic [63:0] up;
		logic [63:0] v;
		logic        neg;
		case (sel)
			TBL_ONE: begin
				th  = ((i / DIV_ONE) << 56) + (((i % DIV_ONE) << 56) / DIV_ONE);
				amp = AMP_ONE;
			end
			TBL_TWO: begin
				th  = ((i / DIV_TWO) << 56) + (((i % DIV_TWO) << 56) / DIV_TWO);
				amp = AMP_TWO;
			end
			TBL_THREE: begin
				th  = ((i / DIV_THREE) << 56) + (((i % DIV_THREE) << 56) / DIV_THREE);
				amp = AMP_THREE;
			end
			default: begin
				th  = 64'd0;
				amp = 64'd0;
			end
		endcase
		neg = 1'b0;
		th  = th % TWO_PI_Q56;
		if (th >= PI_Q56) begin
			th  = th - PI_Q56;
			neg = 1'b1;
		end
		if (th > HALF_PI_Q56) begin
			th = PI_Q56 - th;
		end
		x    = th << 6;
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			term = mul_q62(term, x2) / SERIES_DEN[k];
			if (k[0] == 1'b0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		p = (sum >> 6) * amp;
		if (!neg) begin
			v = amp + (p >> 56);
		end else begin
			up = (p + ONE_Q56 - 64'd1) >> 56;
			v  = (up > amp) ? 64'd0 : amp - up;
		end
		return v[7:0];
	endfunction

	// fold, level and rgb565 packing
	function automatic logic [15:0] colour_of(input logic [SUM_W-1:0] sum);
		logic [6:0] c;
		logic [4:0] lvl;
		logic [4:0] g;
		c   = (sum[6:0] > FOLD_POINT || sum[SUM_W-1]) ? 7'(~sum) : sum[6:0];
		lvl = c[6:2];
		g   = LEVEL_MAX - lvl;
		return {lvl, 1'b0, g, g};
	endfunction

endpackage

`default_nettype wire

### rtl/plasma_pixel_pair_generator.sv
// top level: plasma pixel pair generator, three stage rom lookup pipeline
// an accepted transaction passes the first rom reads, the inner rom reads and the colour register,
// in that order; its delay is set by the two dependent rom reads and the colour register
// throughput: one pixel pair per cycle, every stage takes a new transaction each cycle
// busy stays low; the receiver cannot stall and done is a one-cycle strobe
// reset clears only the valid pipeline; the roms are constant and need no fill
`default_nettype none

module plasma_pixel_pair_generator import ppg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [9:0]  column,
	input  wire logic [9:0]  row,
	input  wire logic [8:0]  offset_a,
	input  wire logic [8:0]  offset_b,
	input  wire logic [9:0]  offset_c,
	output logic             done,
	output logic      [15:0] pixel_even,
	output logic      [15:0] pixel_odd
);

	logic                  accept;
	logic [ADDR_SUM_W-1:0] col_e;
	logic [ADDR_SUM_W-1:0] col_o;
	logic [ADDR_SUM_W-1:0] row_w;
	logic [ADDR_SUM_W-1:0] off_a;
	logic [ADDR_SUM_W-1:0] off_b;
	logic [ADDR_SUM_W-1:0] off_c;

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic [9:0]            c_s1;
	logic [7:0]            two_yb_s1;
	logic [7:0]            three_ya_s1;
	logic [7:0]            two_xb_e_s1;
	logic [7:0]            two_xb_o_s1;
	logic [7:0]            one_xa_e_s1;
	logic [7:0]            one_xa_o_s1;
	logic [7:0]            three_xyc_e_s1;
	logic [7:0]            three_xyc_o_s1;

	logic [INNER_W-1:0]    inner_e;
	logic [INNER_W-1:0]    inner_o;
	logic [SUM_W-1:0]      part_e;
	logic [SUM_W-1:0]      part_o;
	logic [SUM_W-1:0]      part_e_s2;
	logic [SUM_W-1:0]      part_o_s2;
	logic [7:0]            one_in_e_s2;
	logic [7:0]            one_in_o_s2;

	logic [SUM_W-1:0]      sum_e;
	logic [SUM_W-1:0]      sum_o;
	logic [15:0]           pixel_even_s3;
	logic [15:0]           pixel_odd_s3;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign col_e = ADDR_SUM_W'(column);
	assign col_o = ADDR_SUM_W'(column) + ADDR_SUM_W'(1);
	assign row_w = ADDR_SUM_W'(row);
	assign off_a = ADDR_SUM_W'(offset_a);
	assign off_b = ADDR_SUM_W'(offset_b);
	assign off_c = ADDR_SUM_W'(offset_c);

	// first lookup stage
	ppg_sine_rom #(.ROM_SEL(TBL_TWO)) u_two_yb (
		.clk  (clk),
		.addr (IDX_W'(row_w + off_b)),
		.data (two_yb_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_THREE)) u_three_ya (
		.clk  (clk),
		.addr (IDX_W'(row_w + off_a)),
		.data (three_ya_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_TWO)) u_two_xb_e (
		.clk  (clk),
		.addr (IDX_W'(col_e + off_b)),
		.data (two_xb_e_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_TWO)) u_two_xb_o (
		.clk  (clk),
		.addr (IDX_W'(col_o + off_b)),
		.data (two_xb_o_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_ONE)) u_one_xa_e (
		.clk  (clk),
		.addr (IDX_W'(col_e + off_a)),
		.data (one_xa_e_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_ONE)) u_one_xa_o (
		.clk  (clk),
		.addr (IDX_W'(col_o + off_a)),
		.data (one_xa_o_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_THREE)) u_three_xyc_e (
		.clk  (clk),
		.addr (IDX_W'(col_e + row_w + off_c)),
		.data (three_xyc_e_s1)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_THREE)) u_three_xyc_o (
		.clk  (clk),
		.addr (IDX_W'(col_o + row_w + off_c)),
		.data (three_xyc_o_s1)
	);

	always_ff @(posedge clk) begin
		c_s1 <= offset_c;
	end

	// nested index and partial sums
	assign inner_e = INNER_W'(two_xb_e_s1) + INNER_W'(three_ya_s1) + INNER_W'(c_s1);
	assign inner_o = INNER_W'(two_xb_o_s1) + INNER_W'(three_ya_s1) + INNER_W'(c_s1);
	assign part_e  = SUM_W'(one_xa_e_s1) + SUM_W'(two_yb_s1) + SUM_W'(three_xyc_e_s1);
	assign part_o  = SUM_W'(one_xa_o_s1) + SUM_W'(two_yb_s1) + SUM_W'(three_xyc_o_s1);

	ppg_sine_rom #(.ROM_SEL(TBL_ONE)) u_one_in_e (
		.clk  (clk),
		.addr (IDX_W'(inner_e)),
		.data (one_in_e_s2)
	);

	ppg_sine_rom #(.ROM_SEL(TBL_ONE)) u_one_in_o (
		.clk  (clk),
		.addr (IDX_W'(inner_o)),
		.data (one_in_o_s2)
	);

	always_ff @(posedge clk) begin
		part_e_s2 <= part_e;
		part_o_s2 <= part_o;
	end

	assign sum_e = part_e_s2 + SUM_W'(one_in_e_s2);
	assign sum_o = part_o_s2 + SUM_W'(one_in_o_s2);

	always_ff @(posedge clk) begin
		pixel_even_s3 <= colour_of(sum_e);
		pixel_odd_s3  <= colour_of(sum_o);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign done       = valid_s3;
	assign pixel_even = pixel_even_s3;
	assign pixel_odd  = pixel_odd_s3;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result strobe without a transaction three cycles earlier");

	a_even_colour: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pixel_even[10] == 1'b0 && pixel_even[4:0] == pixel_even[9:5]
			&& (pixel_even[15:11] + pixel_even[9:5]) == LEVEL_MAX))
		else $error("even pixel is not a valid palette colour");

	a_odd_colour: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pixel_odd[10] == 1'b0 && pixel_odd[4:0] == pixel_odd[9:5]
			&& (pixel_odd[15:11] + pixel_odd[9:5]) == LEVEL_MAX))
		else $error("odd pixel is not a valid palette colour");
`endif

endmodule

`default_nettype wire

### rtl/ppg_sine_rom.sv
// sine lookup rom with one registered read port
`default_nettype none

module ppg_sine_rom import ppg_pkg::*; #(
	parameter table_sel_t ROM_SEL = TBL_ONE
) (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] addr,
	output logic      [7:0]       data
);

	logic [7:0] rom_w [TABLE_SIZE];
	logic [7:0] data_q;

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
		localparam logic [7:0] ENTRY = sine_entry(64'(i), ROM_SEL);
		assign rom_w[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

### sim/tb_plasma_pixel_pair_generator.sv
// self-checking testbench for the plasma pixel pair generator
module tb_plasma_pixel_pair_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROM_DEPTH      = 4096;
	localparam int PALETTE_DEPTH  = 256;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
	localparam logic [63:0] PI_Q56      = PI_Q62 >> 6;
	localparam logic [63:0] TWO_PI_Q56  = PI_Q56 * 64'd2;
	localparam logic [63:0] HALF_PI_Q56 = PI_Q62 >> 7;
	localparam logic [63:0] ONE_Q56     = 64'd1 << 56;

	typedef struct {
		logic [9:0] x;
		logic [9:0] y;
		logic [8:0] phase_a;
		logic [8:0] phase_b;
		logic [9:0] phase_c;
	} raster_item_t;

	typedef struct {
		logic [15:0] even;
		logic [15:0] odd;
	} pixel_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [9:0]  column = '0;
	logic [9:0]  row = '0;
	logic [8:0]  offset_a = '0;
	logic [8:0]  offset_b = '0;
	logic [9:0]  offset_c = '0;
	logic        done;
	logic [15:0] pixel_even;
	logic [15:0] pixel_odd;

	logic [7:0]   wave_one [ROM_DEPTH];
	logic [7:0]   wave_two [ROM_DEPTH];
	logic [7:0]   wave_three [ROM_DEPTH];
	raster_item_t raster_items[$];
	pixel_pair_t  queued_pixel_pairs[$];
	int           total_items = 0;
	int           accepted_items = 0;
	int           mismatches = 0;
	int           quiet_cycles = 0;

	plasma_pixel_pair_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.column     (column),
		.row        (row),
		.offset_a   (offset_a),
		.offset_b   (offset_b),
		.offset_c   (offset_c),
		.done       (done),
		.pixel_even (pixel_even),
		.pixel_odd  (pixel_odd)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		return full[125:62];
	endfunction

	// floor(sin(idx/divisor)*amp + amp), fixed point with truncated products and quotients
	function automatic logic [7:0] sine_byte(input int unsigned idx, input int unsigned divisor,
			input int unsigned amp);
		logic [63:0] i64;
		logic [63:0] d64;
		logic [63:0] a64;
		logic [63:0] angle;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] p;
		logic [63:0] up;
		logic [63:0] v;
		logic        negative;
		i64 = 64'(idx);
		d64 = 64'(divisor);
		a64 = 64'(amp);
		angle = ((i64 / d64) << 56) + (((i64 % d64) << 56) / d64);
		angle = angle % TWO_PI_Q56;
		negative = 1'b0;
		if (angle >= PI_Q56) begin
			angle = angle - PI_Q56;
			negative = 1'b1;
		end
		if (angle > HALF_PI_Q56)
			angle = PI_Q56 - angle;
		x = angle << 6;
		x2 = q62_product(x, x);
		term = x;
		acc = x;
		for (int n = 3; n <= 27; n += 2) begin
			term = q62_product(term, x2) / 64'((n - 1) * n);
			if (((n >> 1) & 1) == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		p = (acc >> 6) * a64;
		if (!negative) begin
			v = a64 + (p >> 56);
		end else begin
			up = (p + ONE_Q56 - 64'd1) >> 56;
			v = (up > a64) ? 64'd0 : a64 - up;
		end
		return v[7:0];
	endfunction

	// fold at 127, quarter to a level, red rises while green and blue fall
	function automatic logic [15:0] shade(input int unsigned total);
		int unsigned c;
		int unsigned lvl;
		c = total % PALETTE_DEPTH;
		if (c > 127)
			c = 255 - c;
		lvl = c >> 2;
		return 16'((lvl << 11) | ((31 - lvl) << 5) | (31 - lvl));
	endfunction

	function automatic logic [15:0] plasma_pixel(input int unsigned x, input int unsigned y,
			input int unsigned a, input int unsigned b, input int unsigned c,
			input int unsigned row_two, input int unsigned row_three);
		int unsigned nested;
		int unsigned total;
		nested = wave_two[(x + b) % ROM_DEPTH] + row_three + c;
		total = wave_one[(x + a) % ROM_DEPTH] + row_two
			+ wave_three[(x + y + c) % ROM_DEPTH] + wave_one[nested % ROM_DEPTH];
		return shade(total);
	endfunction

	function automatic pixel_pair_t plasma_pair(input logic [9:0] x, input logic [9:0] y,
			input logic [8:0] a, input logic [8:0] b, input logic [9:0] c);
		pixel_pair_t pair;
		int unsigned row_two;
		int unsigned row_three;
		row_two = wave_two[(y + b) % ROM_DEPTH];
		row_three = wave_three[(y + a) % ROM_DEPTH];
		pair.even = plasma_pixel(x, y, a, b, c, row_two, row_three);
		pair.odd = plasma_pixel(x + 1, y, a, b, c, row_two, row_three);
		return pair;
	endfunction

	function automatic void add_item(input int unsigned x, input int unsigned y,
			input int unsigned a, input int unsigned b, input int unsigned c);
		raster_item_t item;
		item.x = 10'(x);
		item.y = 10'(y);
		item.phase_a = 9'(a);
		item.phase_b = 9'(b);
		item.phase_c = 10'(c);
		raster_items.push_back(item);
	endfunction

	function automatic bit sender_idles();
		int unsigned pct;
		if (accepted_items < total_items / 3)
			pct = 34;
		else if (accepted_items < (2 * total_items) / 3)
			pct = 82;
		else
			pct = 0;
		return $urandom_range(99) < pct;
	endfunction

	task automatic note_mismatch(input string what, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch %s: expected %h got %h at %0t", what, exp_v, act_v, $realtime);
	endtask

	// driver
	always @(posedge clk) begin
		raster_item_t item;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				queued_pixel_pairs.push_back(plasma_pair(column, row, offset_a, offset_b,
					offset_c));
				accepted_items++;
			end
			if (start && busy) begin
				// transaction not taken yet, hold it
			end else if (raster_items.size() > 0 && !sender_idles()) begin
				item = raster_items.pop_front();
				column <= item.x;
				row <= item.y;
				offset_a <= item.phase_a;
				offset_b <= item.phase_b;
				offset_c <= item.phase_c;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		pixel_pair_t want;
		if (arst_n) begin
			if (done) begin
				if (queued_pixel_pairs.size() == 0) begin
					note_mismatch("unexpected pair, even", 16'h0, pixel_even);
				end else begin
					want = queued_pixel_pairs.pop_front();
					if (pixel_even !== want.even)
						note_mismatch("pixel_even", want.even, pixel_even);
					if (pixel_odd !== want.odd)
						note_mismatch("pixel_odd", want.odd, pixel_odd);
				end
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pick;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			wave_one[i] = sine_byte(i, 45, 63);
			wave_two[i] = sine_byte(i, 75, 42);
			wave_three[i] = sine_byte(i, 32, 88);
		end

		// field extremes, odd columns and full-width values
		add_item(0, 0, 0, 0, 0);
		add_item(1022, 1023, 264, 496, 760);
		add_item(1022, 0, 0, 0, 0);
		add_item(0, 1023, 0, 0, 0);
		add_item(0, 0, 264, 0, 0);
		add_item(0, 0, 0, 496, 0);
		add_item(0, 0, 0, 0, 760);
		add_item(1, 0, 0, 0, 0);
		add_item(1023, 1023, 511, 511, 1023);
		add_item(1023, 0, 0, 0, 0);
		add_item(0, 0, 511, 0, 0);
		add_item(0, 0, 0, 511, 0);
		add_item(0, 0, 0, 0, 1023);
		add_item(512, 512, 132, 248, 380);
		add_item(511, 511, 256, 256, 512);
		add_item(1022, 1023, 0, 0, 1023);
		add_item(2, 1, 1, 1, 1);
		add_item(682, 341, 170, 341, 682);
		add_item(340, 681, 85, 170, 341);
		add_item(1000, 1000, 264, 496, 760);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				add_item($urandom_range(511) * 2, $urandom_range(1023), $urandom_range(264),
					$urandom_range(496), $urandom_range(760));
			else if (pick < 90)
				add_item($urandom_range(511) * 2 + 1, $urandom_range(1023),
					$urandom_range(264), $urandom_range(496), $urandom_range(760));
			else
				add_item($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
					$urandom_range(511), $urandom_range(1023));
		end
		total_items = raster_items.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (raster_items.size() > 0 || start || queued_pixel_pairs.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && queued_pixel_pairs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
